/* rtl/adsr_envelope_generator_macros.svh */
// Assertion helpers shared by the envelope generator modules.
// Both expect a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ADSR_ENVELOPE_GENERATOR_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ADSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/adsr_pkg.sv */
`timescale 1ns / 1ps

package adsr_pkg;

    localparam int TICK_BITS     = 24;
    localparam int CFG_DATA_BITS = 24;
    localparam int CFG_ADDR_BITS = 3;
    localparam int FUNC_BITS     = 2;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_ATTACK  = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DECAY   = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RELEASE = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SUSTAIN = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_START   = 3'd4;

    localparam logic [TICK_BITS-1:0] ATTACK_RESET  = 24'd480;
    localparam logic [TICK_BITS-1:0] DECAY_RESET   = 24'd4800;
    localparam logic [TICK_BITS-1:0] RELEASE_RESET = 24'd4800;

    localparam logic [FUNC_BITS-1:0] FUNC_NOTE_ON  = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_NOTE_OFF = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_DIFF,
        OP_CLASS,
        OP_MUL_ATK,
        OP_MUL_D1,
        OP_MUL_D2,
        OP_MUL_REL,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_SAT,
        OP_ZERO,
        OP_THR,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        PH_RAW,
        PH_NEG,
        PH_ATK,
        PH_DEC,
        PH_SUS
    } phase_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        phase_t phase;
        logic   gate;
        logic   rel_zero;
        logic   sat;
        logic   div_last;
        logic   out_free;
    } status_t;

endpackage

/* rtl/adsr_ctrl.sv */
`timescale 1ns / 1ps
`include "adsr_envelope_generator_macros.svh"

module adsr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  adsr_pkg::status_t status,
    output adsr_pkg::cmd_t    cmd
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_DIFF    = 13'b0000000000010,
        S_CLASS   = 13'b0000000000100,
        S_MUL_ATK = 13'b0000000001000,
        S_MUL_D1  = 13'b0000000010000,
        S_MUL_D2  = 13'b0000000100000,
        S_LD_LVL  = 13'b0000001000000,
        S_DIV_LVL = 13'b0000010000000,
        S_REL     = 13'b0000100000000,
        S_LD_REL  = 13'b0001000000000,
        S_DIV_REL = 13'b0010000000000,
        S_THR     = 13'b0100000000000,
        S_OUT     = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = adsr_pkg::OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = adsr_pkg::OP_ACCEPT;
                    state_next = S_DIFF;
                end
            end
            S_DIFF: begin
                cmd.op     = adsr_pkg::OP_DIFF;
                state_next = S_CLASS;
            end
            S_CLASS: begin
                cmd.op = adsr_pkg::OP_CLASS;
                case (status.phase)
                    adsr_pkg::PH_RAW: state_next = S_OUT;
                    adsr_pkg::PH_ATK: state_next = S_MUL_ATK;
                    adsr_pkg::PH_DEC: state_next = S_MUL_D1;
                    default:          state_next = S_REL;
                endcase
            end
            S_MUL_ATK: begin
                cmd.op     = adsr_pkg::OP_MUL_ATK;
                state_next = S_LD_LVL;
            end
            S_MUL_D1: begin
                cmd.op     = adsr_pkg::OP_MUL_D1;
                state_next = S_MUL_D2;
            end
            S_MUL_D2: begin
                cmd.op     = adsr_pkg::OP_MUL_D2;
                state_next = S_LD_LVL;
            end
            S_LD_LVL: begin
                cmd.op     = adsr_pkg::OP_DIV_LOAD;
                state_next = S_DIV_LVL;
            end
            S_DIV_LVL: begin
                cmd.op = adsr_pkg::OP_DIV_STEP;
                if (status.div_last) begin
                    state_next = S_REL;
                end
            end
            S_REL: begin
                if (status.gate) begin
                    state_next = S_THR;
                end else if (status.rel_zero) begin
                    cmd.op     = adsr_pkg::OP_ZERO;
                    state_next = S_THR;
                end else begin
                    cmd.op     = adsr_pkg::OP_MUL_REL;
                    state_next = S_LD_REL;
                end
            end
            S_LD_REL: begin
                if (status.sat) begin
                    cmd.op     = adsr_pkg::OP_SAT;
                    state_next = S_THR;
                end else begin
                    cmd.op     = adsr_pkg::OP_DIV_LOAD;
                    state_next = S_DIV_REL;
                end
            end
            S_DIV_REL: begin
                cmd.op = adsr_pkg::OP_DIV_STEP;
                if (status.div_last) begin
                    state_next = S_THR;
                end
            end
            S_THR: begin
                cmd.op     = adsr_pkg::OP_THR;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.op     = adsr_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `ADSR_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_reg == S_DIFF, "accepted word did not start evaluation")
    `ADSR_ASSERT_NEXT(a_level_div_done, state_reg == S_DIV_LVL && status.div_last, state_reg == S_REL, "level division did not hand over to release")
    `ADSR_ASSERT_NEXT(a_rel_div_done, state_reg == S_DIV_REL && status.div_last, state_reg == S_THR, "release division did not finish")

endmodule

/* rtl/adsr_dp.sv */
`timescale 1ns / 1ps
`include "adsr_envelope_generator_macros.svh"

module adsr_dp #(
    parameter int TIME_BITS  = 32,
    parameter int LEVEL_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [adsr_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [adsr_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic [((TIME_BITS+7)/8)*8-1:0]       s_tdata,
    input  logic [adsr_pkg::FUNC_BITS-1:0]       s_tuser,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [((LEVEL_BITS+7)/8)*8-1:0]      m_tdata,
    output logic [0:0]                           m_tuser,
    input  adsr_pkg::cmd_t                       cmd,
    output adsr_pkg::status_t                    status
);

    localparam int KB       = adsr_pkg::TICK_BITS;
    localparam int MAXB     = (TIME_BITS > KB) ? TIME_BITS : KB;
    localparam int SW       = MAXB + 2;
    localparam int NB       = MAXB + 1;
    localparam int PB       = LEVEL_BITS + NB;
    localparam int CW       = $clog2(LEVEL_BITS);
    localparam int OUT_W    = ((LEVEL_BITS + 7) / 8) * 8;
    localparam int ZERO_MAX = (1 << LEVEL_BITS) / 10000;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};
    localparam logic [LEVEL_BITS-1:0] SUS_RESET = {1'b1, {(LEVEL_BITS-1){1'b0}}};

    logic [KB-1:0]         attack_reg, attack_next;
    logic [KB-1:0]         decay_reg, decay_next;
    logic [KB-1:0]         release_reg, release_next;
    logic [LEVEL_BITS-1:0] sustain_reg, sustain_next;
    logic [LEVEL_BITS-1:0] start_reg, start_next;
    logic [TIME_BITS-1:0]  on_time_reg, on_time_next;
    logic [TIME_BITS-1:0]  off_time_reg, off_time_next;
    logic                  gate_reg, gate_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic [TIME_BITS-1:0]  t_reg, t_next;
    logic signed [SW-1:0]  lt_reg, lt_next;
    logic signed [SW-1:0]  e_reg, e_next;
    logic signed [SW-1:0]  relnum_reg, relnum_next;
    logic [KB:0]           ad_reg, ad_next;
    logic                  fin_reg, fin_next;
    logic [KB-1:0]         d_reg, d_next;
    logic [KB-1:0]         dd_reg, dd_next;
    logic [LEVEL_BITS-1:0] amp_reg, amp_next;
    logic [PB-1:0]         prod_reg, prod_next;
    logic [PB-1:0]         acc_reg, acc_next;
    logic [KB-1:0]         den_reg, den_next;
    logic [KB-1:0]         div_rem_reg, div_rem_next;
    logic [LEVEL_BITS-1:0] div_low_reg, div_low_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [LEVEL_BITS-1:0] m_amp_reg, m_amp_next;
    logic                  m_fin_reg, m_fin_next;

    logic signed [SW-1:0]  t_ext, on_ext, off_ext, a_ext, r_ext, ad_ext;
    logic signed [SW-1:0]  lt_diff, e_diff, d_full;
    logic [TIME_BITS-1:0]  s_time;
    logic [LEVEL_BITS-1:0] mul_a;
    logic [NB-1:0]         mul_b;
    logic [PB-1:0]         mul_p;
    logic [PB-1:0]         div_sum;
    logic [PB-1:0]         rel_lim;
    logic [KB+1:0]         trial;
    logic                  q_bit;
    logic [LEVEL_BITS-1:0] low_shift;
    adsr_pkg::phase_t      phase;

    assign s_time  = s_tdata[TIME_BITS-1:0];
    assign t_ext   = $signed({{(SW-TIME_BITS){1'b0}}, t_reg});
    assign on_ext  = $signed({{(SW-TIME_BITS){1'b0}}, on_time_reg});
    assign off_ext = $signed({{(SW-TIME_BITS){1'b0}}, off_time_reg});
    assign a_ext   = $signed({{(SW-KB){1'b0}}, attack_reg});
    assign r_ext   = $signed({{(SW-KB){1'b0}}, release_reg});
    assign ad_ext  = $signed({{(SW-KB-1){1'b0}}, ad_reg});
    assign lt_diff = t_ext - on_ext;
    assign e_diff  = t_ext - off_ext;
    assign d_full  = lt_reg - a_ext;

    always_comb begin
        if (lt_reg <= a_ext) begin
            if (attack_reg == '0) begin
                phase = adsr_pkg::PH_RAW;
            end else if (lt_reg[SW-1]) begin
                phase = adsr_pkg::PH_NEG;
            end else begin
                phase = adsr_pkg::PH_ATK;
            end
        end else if (lt_reg <= ad_ext) begin
            phase = adsr_pkg::PH_DEC;
        end else begin
            phase = adsr_pkg::PH_SUS;
        end
    end

    always_comb begin
        case (cmd.op)
            adsr_pkg::OP_MUL_ATK: begin
                mul_a = start_reg;
                mul_b = {{(NB-KB){1'b0}}, lt_reg[KB-1:0]};
            end
            adsr_pkg::OP_MUL_D1: begin
                mul_a = sustain_reg;
                mul_b = {{(NB-KB){1'b0}}, d_reg};
            end
            adsr_pkg::OP_MUL_REL: begin
                mul_a = amp_reg;
                mul_b = relnum_reg[NB-1:0];
            end
            default: begin
                mul_a = start_reg;
                mul_b = {{(NB-KB){1'b0}}, dd_reg};
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign div_sum   = acc_reg + prod_reg;
    assign rel_lim   = {{(PB-KB-LEVEL_BITS){1'b0}}, release_reg, {LEVEL_BITS{1'b0}}};
    assign trial     = {1'b0, div_rem_reg, div_low_reg[LEVEL_BITS-1]} - {2'b00, den_reg};
    assign q_bit     = !trial[KB+1];
    assign low_shift = {div_low_reg[LEVEL_BITS-2:0], q_bit};

    assign status.phase    = phase;
    assign status.gate     = gate_reg;
    assign status.rel_zero = (release_reg == '0) || relnum_reg[SW-1] || (relnum_reg == '0);
    assign status.sat      = (prod_reg >= rel_lim);
    assign status.div_last = (cnt_reg == CW'(LEVEL_BITS - 1));
    assign status.out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        attack_next   = attack_reg;
        decay_next    = decay_reg;
        release_next  = release_reg;
        sustain_next  = sustain_reg;
        start_next    = start_reg;
        on_time_next  = on_time_reg;
        off_time_next = off_time_reg;
        gate_next     = gate_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        t_next        = t_reg;
        lt_next       = lt_reg;
        e_next        = e_reg;
        relnum_next   = relnum_reg;
        ad_next       = ad_reg;
        fin_next      = fin_reg;
        d_next        = d_reg;
        dd_next       = dd_reg;
        amp_next      = amp_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        den_next      = den_reg;
        div_rem_next  = div_rem_reg;
        div_low_next  = div_low_reg;
        cnt_next      = cnt_reg;
        m_amp_next    = m_amp_reg;
        m_fin_next    = m_fin_reg;

        if (cfg_wr_en) begin
            case (cfg_addr)
                adsr_pkg::CFG_ATTACK:  attack_next  = cfg_wdata[KB-1:0];
                adsr_pkg::CFG_DECAY:   decay_next   = cfg_wdata[KB-1:0];
                adsr_pkg::CFG_RELEASE: release_next = cfg_wdata[KB-1:0];
                adsr_pkg::CFG_SUSTAIN: sustain_next = cfg_wdata[LEVEL_BITS-1:0];
                adsr_pkg::CFG_START:   start_next   = cfg_wdata[LEVEL_BITS-1:0];
                default: begin
                end
            endcase
        end

        case (cmd.op)
            adsr_pkg::OP_ACCEPT: begin
                t_next = s_time;
                case (s_tuser)
                    adsr_pkg::FUNC_NOTE_ON: begin
                        on_time_next = s_time;
                        gate_next    = 1'b1;
                    end
                    adsr_pkg::FUNC_NOTE_OFF: begin
                        off_time_next = s_time;
                        gate_next     = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            adsr_pkg::OP_DIFF: begin
                lt_next  = lt_diff;
                e_next   = e_diff;
                fin_next = !gate_reg && (e_diff > r_ext);
                ad_next  = {1'b0, attack_reg} + {1'b0, decay_reg};
            end
            adsr_pkg::OP_CLASS: begin
                d_next      = d_full[KB-1:0];
                relnum_next = r_ext - e_reg;
                case (phase)
                    adsr_pkg::PH_RAW: amp_next = start_reg;
                    adsr_pkg::PH_NEG: amp_next = '0;
                    adsr_pkg::PH_SUS: amp_next = sustain_reg;
                    default: begin
                    end
                endcase
            end
            adsr_pkg::OP_MUL_ATK: begin
                prod_next = mul_p;
                acc_next  = '0;
                den_next  = attack_reg;
            end
            adsr_pkg::OP_MUL_D1: begin
                prod_next = mul_p;
                dd_next   = decay_reg - d_reg;
            end
            adsr_pkg::OP_MUL_D2: begin
                acc_next  = prod_reg;
                prod_next = mul_p;
                den_next  = decay_reg;
            end
            adsr_pkg::OP_MUL_REL: begin
                prod_next = mul_p;
                acc_next  = '0;
                den_next  = release_reg;
            end
            adsr_pkg::OP_DIV_LOAD: begin
                div_rem_next = div_sum[LEVEL_BITS +: KB];
                div_low_next = div_sum[LEVEL_BITS-1:0];
                cnt_next     = '0;
            end
            adsr_pkg::OP_DIV_STEP: begin
                if (q_bit) begin
                    div_rem_next = trial[KB-1:0];
                end else begin
                    div_rem_next = {div_rem_reg[KB-2:0], div_low_reg[LEVEL_BITS-1]};
                end
                div_low_next = low_shift;
                cnt_next     = cnt_reg + 1'b1;
                if (status.div_last) begin
                    amp_next = low_shift;
                end
            end
            adsr_pkg::OP_SAT: begin
                amp_next = LEVEL_MAX;
            end
            adsr_pkg::OP_ZERO: begin
                amp_next = '0;
            end
            adsr_pkg::OP_THR: begin
                if (amp_reg <= LEVEL_BITS'(ZERO_MAX)) begin
                    amp_next = '0;
                end
            end
            adsr_pkg::OP_OUT: begin
                m_amp_next    = amp_reg;
                m_fin_next    = fin_reg;
                m_tvalid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg   <= adsr_pkg::ATTACK_RESET;
            decay_reg    <= adsr_pkg::DECAY_RESET;
            release_reg  <= adsr_pkg::RELEASE_RESET;
            sustain_reg  <= SUS_RESET;
            start_reg    <= LEVEL_MAX;
            on_time_reg  <= '0;
            off_time_reg <= '0;
            gate_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            attack_reg   <= attack_next;
            decay_reg    <= decay_next;
            release_reg  <= release_next;
            sustain_reg  <= sustain_next;
            start_reg    <= start_next;
            on_time_reg  <= on_time_next;
            off_time_reg <= off_time_next;
            gate_reg     <= gate_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg       <= t_next;
        lt_reg      <= lt_next;
        e_reg       <= e_next;
        relnum_reg  <= relnum_next;
        ad_reg      <= ad_next;
        fin_reg     <= fin_next;
        d_reg       <= d_next;
        dd_reg      <= dd_next;
        amp_reg     <= amp_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        den_reg     <= den_next;
        div_rem_reg <= div_rem_next;
        div_low_reg <= div_low_next;
        cnt_reg     <= cnt_next;
        m_amp_reg   <= m_amp_next;
        m_fin_reg   <= m_fin_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = OUT_W'(m_amp_reg);
    assign m_tuser[0] = m_fin_reg;

    `ADSR_ASSERT_NOW(a_out_free, cmd.op == adsr_pkg::OP_OUT, !m_tvalid_reg || m_tready, "pending output word overwritten")
    `ADSR_ASSERT_NEXT(a_note_on, cmd.op == adsr_pkg::OP_ACCEPT && s_tuser == adsr_pkg::FUNC_NOTE_ON, gate_reg && on_time_reg == $past(s_time), "note-on not recorded")
    `ADSR_ASSERT_NEXT(a_threshold, cmd.op == adsr_pkg::OP_THR, amp_reg == '0 || amp_reg > LEVEL_BITS'(ZERO_MAX), "level below threshold not cleared")

endmodule

/* rtl/adsr_envelope_generator.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Contents
// s_        in         s_tvalid/s_tready   tdata: time_req; tuser: func
// m_        out        m_tvalid/m_tready   tdata: amplitude; tuser: finished
// cfg_      in         cfg_wr_en           cfg_addr register index, cfg_wdata value
//
// One word is evaluated at a time by a shared multiplier and a one-bit-per-cycle divider.
// A start level returned raw passes the diff, classify and output states; a level that
// needs no division with the gate on also passes the release check and the threshold; the
// longest path runs both a level division and a release division.
// A finished word waits in the output register while the next word is accepted; while
// that register is still full, the next word holds in its last state and the input stalls.
// Reset is synchronous and active low; it restores the register defaults and the gate.

module adsr_envelope_generator #(
    parameter int TIME_BITS  = 32,
    parameter int LEVEL_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [adsr_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [adsr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((TIME_BITS+7)/8)*8-1:0]      s_tdata,   // time_req
    input  logic [adsr_pkg::FUNC_BITS-1:0]      s_tuser,   // func
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((LEVEL_BITS+7)/8)*8-1:0]     m_tdata,   // amplitude
    output logic [0:0]                          m_tuser    // finished
);

    adsr_pkg::cmd_t    cmd;
    adsr_pkg::status_t status;

    adsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    adsr_dp #(
        .TIME_BITS  (TIME_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam logic [adsr_pkg::FUNC_BITS-1:0] FUNC_QUERY = 2'd0;
    localparam logic [adsr_pkg::FUNC_BITS-1:0] FUNC_SPARE = 2'd3;
    localparam longint LEVEL_TOP = 65535;
    localparam longint LEVEL_FLOOR = 65536 / 10000;
    localparam int SETTLE_CYCLES = 2 * 16 + 12 + 8;
    localparam int WORDS_PER_SETTING = 136;
    localparam int SETTINGS_COUNT = 12;

    typedef struct packed {
        logic [adsr_pkg::FUNC_BITS-1:0] func;
        logic [31:0]                    time_req;
    } envelope_word_t;

    typedef struct packed {
        logic [15:0] amplitude;
        logic        finished;
    } level_word_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               cfg_wr_en = 1'b0;
    logic [adsr_pkg::CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [adsr_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [31:0]                        s_tdata = '0;
    logic [adsr_pkg::FUNC_BITS-1:0]     s_tuser = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [15:0]                        m_tdata;
    logic [0:0]                         m_tuser;

    logic [adsr_pkg::TICK_BITS-1:0] atk_ticks = adsr_pkg::ATTACK_RESET;
    logic [adsr_pkg::TICK_BITS-1:0] dec_ticks = adsr_pkg::DECAY_RESET;
    logic [adsr_pkg::TICK_BITS-1:0] rel_ticks = adsr_pkg::RELEASE_RESET;
    logic [15:0]                    sus_level = 16'd32768;
    logic [15:0]                    peak_level = 16'd65535;
    logic [31:0]                    on_stamp = '0;
    logic [31:0]                    off_stamp = '0;
    logic                           gate_on = 1'b0;

    envelope_word_t pending_words[$];
    level_word_t    level_expected[$];
    envelope_word_t offered;
    level_word_t    want;
    int             tx_idle_pct = 32;
    int             rx_idle_pct = 68;
    int             rx_hold_req = 0;
    int             rx_hold_left = 0;
    int             mismatches = 0;

    adsr_envelope_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 aclk = ~aclk;

    function automatic level_word_t advance_envelope(envelope_word_t w);
        longint      lt, el, lvl, num, q, r, a, dd, rl, st, su, d;
        level_word_t res;
        a = longint'({40'd0, atk_ticks});
        dd = longint'({40'd0, dec_ticks});
        rl = longint'({40'd0, rel_ticks});
        st = longint'({48'd0, peak_level});
        su = longint'({48'd0, sus_level});
        if (w.func == adsr_pkg::FUNC_NOTE_ON) begin
            on_stamp = w.time_req;
            gate_on = 1'b1;
        end else if (w.func == adsr_pkg::FUNC_NOTE_OFF) begin
            off_stamp = w.time_req;
            gate_on = 1'b0;
        end
        lt = longint'({32'd0, w.time_req}) - longint'({32'd0, on_stamp});
        el = longint'({32'd0, w.time_req}) - longint'({32'd0, off_stamp});
        res.finished = !gate_on && el > rl;
        if (a == 0 && lt <= 0) begin
            res.amplitude = peak_level;
            return res;
        end
        if (lt <= a) begin
            lvl = (lt < 0) ? 0 : (lt * st) / a;
        end else if (lt <= a + dd) begin
            d = lt - a;
            lvl = (st * (dd - d) + su * d) / dd;
        end else begin
            lvl = su;
        end
        if (!gate_on) begin
            num = rl - el;
            if (rl == 0 || lvl == 0 || num <= 0) begin
                lvl = 0;
            end else begin
                q = num / rl;
                r = num % rl;
                if (q > LEVEL_TOP) begin
                    lvl = LEVEL_TOP;
                end else begin
                    lvl = lvl * q + (lvl * r) / rl;
                    if (lvl > LEVEL_TOP)
                        lvl = LEVEL_TOP;
                end
            end
        end
        if (lvl <= LEVEL_FLOOR)
            lvl = 0;
        res.amplitude = lvl[15:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                level_expected.push_back(advance_envelope(offered));
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    offered = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= offered.time_req;
                    s_tuser <= offered.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (level_expected.size() == 0) begin
                    $error("unexpected word: amplitude %0d finished %0d", m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    want = level_expected.pop_front();
                    if (m_tdata !== want.amplitude) begin
                        $error("amplitude: expected %0d, actual %0d", want.amplitude, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser[0] !== want.finished) begin
                        $error("finished: expected %0d, actual %0d", want.finished, m_tuser[0]);
                        mismatches++;
                    end
                end
            end
            if (rx_hold_req != 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic queue_word(logic [adsr_pkg::FUNC_BITS-1:0] func, logic [31:0] t);
        envelope_word_t w;
        w.func = func;
        w.time_req = t;
        pending_words.push_back(w);
    endtask

    function automatic logic [adsr_pkg::FUNC_BITS-1:0] query_func();
        return ($urandom_range(0, 7) == 0) ? FUNC_SPARE : FUNC_QUERY;
    endfunction

    function automatic logic [31:0] near(logic [31:0] anchor, int unsigned limit,
                                         int unsigned mark1, int unsigned mark2);
        case ($urandom_range(0, 9))
            0: return anchor + mark1;
            1: return anchor + mark1 + 1;
            2: return anchor + mark2;
            3: return anchor + mark2 + 1;
            4: return anchor - $urandom_range(1, 64);
            default: return anchor + $urandom_range(0, limit);
        endcase
    endfunction

    // One note with random content: queries across attack, decay and sustain,
    // then a release with queries on both sides of its end.
    task automatic queue_gesture(inout int words);
        logic [31:0] base, off_at;
        int unsigned span, rspan, n, a_mark, ad_mark, r_mark;
        a_mark = {8'd0, atk_ticks};
        ad_mark = a_mark + {8'd0, dec_ticks};
        r_mark = {8'd0, rel_ticks};
        base = $urandom();
        span = ad_mark + 16;
        rspan = r_mark + r_mark / 4 + 16;
        queue_word(adsr_pkg::FUNC_NOTE_ON, base);
        n = $urandom_range(1, 6);
        repeat (n) queue_word(query_func(), near(base, span, a_mark, ad_mark));
        off_at = near(base, span, a_mark, ad_mark);
        queue_word(adsr_pkg::FUNC_NOTE_OFF, off_at);
        repeat (n) queue_word(query_func(), near(off_at, rspan, r_mark, 0));
        words += 2 * n + 2;
    endtask

    task automatic queue_noise(inout int words);
        int          n;
        int unsigned f;
        n = $urandom_range(1, 4);
        repeat (n) begin
            f = $urandom_range(0, 3);
            queue_word(f[1:0], $urandom());
        end
        words += n;
    endtask

    task automatic write_reg(logic [adsr_pkg::CFG_ADDR_BITS-1:0] idx,
                             logic [adsr_pkg::CFG_DATA_BITS-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            adsr_pkg::CFG_ATTACK:  atk_ticks = val;
            adsr_pkg::CFG_DECAY:   dec_ticks = val;
            adsr_pkg::CFG_RELEASE: rel_ticks = val;
            adsr_pkg::CFG_SUSTAIN: sus_level = val[15:0];
            adsr_pkg::CFG_START:   peak_level = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_setting(int unsigned a, int unsigned d, int unsigned r,
                                 int unsigned su, int unsigned st);
        write_reg(adsr_pkg::CFG_ATTACK, a[23:0]);
        write_reg(adsr_pkg::CFG_DECAY, d[23:0]);
        write_reg(adsr_pkg::CFG_RELEASE, r[23:0]);
        write_reg(adsr_pkg::CFG_SUSTAIN, {8'd0, su[15:0]});
        write_reg(adsr_pkg::CFG_START, {8'd0, st[15:0]});
    endtask

    function automatic int unsigned rand_ticks();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $urandom_range(1, 4);
            default: return $urandom_range(0, 3000);
        endcase
    endfunction

    function automatic int unsigned rand_level();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(0, 12);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || level_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int words;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Default registers: walk one note through every phase by hand.
        queue_word(FUNC_QUERY, 32'd0);
        queue_word(adsr_pkg::FUNC_NOTE_ON, 32'd1000);
        queue_word(FUNC_QUERY, 32'd1240);
        queue_word(FUNC_QUERY, 32'd1480);
        queue_word(FUNC_QUERY, 32'd1481);
        queue_word(FUNC_QUERY, 32'd3880);
        queue_word(FUNC_QUERY, 32'd6280);
        queue_word(FUNC_QUERY, 32'd9000);
        queue_word(FUNC_SPARE, 32'd9001);
        queue_word(FUNC_QUERY, 32'd900);
        queue_word(adsr_pkg::FUNC_NOTE_OFF, 32'd10000);
        queue_word(FUNC_QUERY, 32'd10000);
        queue_word(FUNC_QUERY, 32'd12400);
        queue_word(FUNC_QUERY, 32'd14800);
        queue_word(FUNC_QUERY, 32'd14801);
        queue_word(FUNC_QUERY, 32'd9500);
        queue_word(FUNC_QUERY, 32'hFFFF_FFFF);
        queue_word(adsr_pkg::FUNC_NOTE_ON, 32'hFFFF_FFFF);
        queue_word(FUNC_QUERY, 32'd0);
        queue_word(adsr_pkg::FUNC_NOTE_OFF, 32'hFFFF_FFF0);
        queue_word(FUNC_QUERY, 32'h8000_0000);
        queue_word(adsr_pkg::FUNC_NOTE_ON, 32'h5555_5555);
        queue_word(FUNC_QUERY, 32'hAAAA_AAAA);

        for (int p = 0; p < SETTINGS_COUNT; p++) begin
            if (p == 4) begin
                tx_idle_pct = 68;
                rx_idle_pct = 32;
            end else if (p == 8) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p != 0) begin
                wait_drained();
                case (p)
                    1: apply_setting(0, 0, 0, rand_level(), rand_level());
                    2: apply_setting(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 0, 65535);
                    3: apply_setting(1, 1, 1, 7, 6);
                    11: apply_setting(rand_ticks(), rand_ticks(), rand_ticks(), 65535, 65535);
                    default: apply_setting(rand_ticks(), rand_ticks(), rand_ticks(),
                                           rand_level(), rand_level());
                endcase
                @(negedge aclk);
            end
            words = 0;
            while (words < WORDS_PER_SETTING) begin
                if ($urandom_range(0, 5) == 0)
                    queue_noise(words);
                else
                    queue_gesture(words);
            end
            if (p == 6)
                rx_hold_req = 400;
        end

        wait_drained();
        if (mismatches == 0)
            $display("[adsr_envelope_generator] OK");
        else
            $display("[adsr_envelope_generator] ERROR");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("[adsr_envelope_generator] ERROR");
        $finish;
    end

endmodule
